@@ rtl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg - shared types and constants for differential drive odometry
// Sequencer states, request kinds, Q.30 angle constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

   // request kinds carried in tuser
   localparam logic [1:0] MODE_SAMPLE  = 2'd0;
   localparam logic [1:0] MODE_SET_X   = 2'd1;
   localparam logic [1:0] MODE_SET_Y   = 2'd2;
   localparam logic [1:0] MODE_SET_HDG = 2'd3;

   // Q.30 angle constants
   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic [38:0]        TWO_PI_MAG  = 39'd6746518852;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

   localparam int           DIV_STEPS = 58;
   localparam logic [2:0]   RED_TOP   = 3'd6;
   localparam logic [15:0]  WD_RESET  = 16'd300;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MID,
      ST_RED,
      ST_FOLD,
      ST_CORD,
      ST_MULX,
      ST_MULY,
      ST_ADDY,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic start;
   } cordic_ctl_type;

   typedef struct packed {
      logic done;
   } cordic_sts_type;

   // truncated Q.30 arctangent of 2^-i
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// ddo_cordic - iterative rotation-mode CORDIC
// One micro-rotation per cycle on a shared shift/add unit; gives sine and
// cosine in Q.30 of an angle folded into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; #(
   parameter int STEPS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  cordic_ctl_type      ctl,
   input  logic signed [33:0]  angle,
   output cordic_sts_type      sts,
   output logic signed [33:0]  sin_out,
   output logic signed [33:0]  cos_out
);

   localparam logic [5:0] LAST = 6'(STEPS - 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, z_ff, z_in;
   logic signed [33:0] dx, dy, at;

   // one micro-rotation
   always_comb begin
      dx      = cy_ff >>> cnt_ff[4:0];
      dy      = cx_ff >>> cnt_ff[4:0];
      at      = 34'(signed'({2'b00, atan_q30(cnt_ff[4:0])}));
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         cx_in   = CORDIC_GAIN;
         cy_in   = '0;
         z_in    = angle;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            z_in  = z_ff - at;
         end else begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            z_in  = z_ff + at;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff  <= z_in;
   end

   assign sts.done = done_ff;
   assign sin_out  = cy_ff;
   assign cos_out  = cx_ff;

   // assertions
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without run");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !done_in |-> !ctl.start) else $error("restart while busy");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= LAST) else $error("step count overrun");

endmodule

@@ rtl/differential_drive_odometry.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry - midpoint dead reckoning for a two-wheel base
// A set request goes from the idle state straight to the final state. An
// encoder sample passes through the bit-serial divider, midpoint, range
// reduction, fold, CORDIC, multiply and update states to the final state,
// which waits until the response register is free.
// Only one request is in flight: a new request is accepted only in the idle
// state, so the block cannot take one before it is through with the last.
// Reset (synchronous) zeroes position, heading and encoder history and sets
// wheel_distance to 300.
// ----------------------------------------------------------------------------
module differential_drive_odometry import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,   // wheel_distance
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,     // mode
   // left_count[31:0], right_count[63:32], new_x[111:64], new_y[159:112],
   // new_heading[191:160]
   input  logic [191:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pos_x[47:0], pos_y[95:48], heading[127:96]
   output logic [127:0]  rsp_tdata
);

   state_type           state_ff, state_in;
   logic [15:0]         wd_ff;
   logic signed [31:0]  last_l_ff, last_r_ff;
   logic signed [47:0]  x_ff, y_ff;
   logic signed [31:0]  h_ff;
   logic signed [33:0]  sum_ff;
   logic                neg_ff;
   logic [57:0]         dvd_ff;
   logic [15:0]         rem_ff;
   logic [31:0]         q_ff;
   logic [5:0]          dcnt_ff;
   logic signed [31:0]  dth_ff;
   logic [38:0]         red_ff;
   logic [2:0]          rk_ff;
   logic                negcos_ff;
   logic signed [65:0]  prod_ff;
   logic                rv_ff;
   logic [127:0]        rd_ff;

   logic                accept;
   logic signed [32:0]  l_w, r_w;
   logic signed [33:0]  diff_w;
   logic [33:0]         mag_w;
   logic [15:0]         wd_eff;
   logic [16:0]         trial;
   logic signed [31:0]  half_w;
   logic signed [32:0]  hsum_w;
   logic signed [38:0]  mid_w;
   logic [38:0]         cmp_w;
   logic signed [34:0]  sred_w, wrap_w, fold_w;
   logic                fneg_w;
   logic signed [33:0]  sin_w, cos_w, cos_adj;
   logic signed [31:0]  sn4, cs4;
   logic signed [65:0]  mul_b;
   logic signed [65:0]  mul_out;
   logic                out_free;
   cordic_ctl_type      cctl;
   cordic_sts_type      csts;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rv_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = (req_tuser == MODE_SAMPLE) ? ST_DIV : ST_FIN;
         ST_DIV:  if (dcnt_ff == 6'(DIV_STEPS - 1)) state_in = ST_MID;
         ST_MID:  state_in = ST_RED;
         ST_RED:  if (rk_ff == 3'd0) state_in = ST_FOLD;
         ST_FOLD: state_in = ST_CORD;
         ST_CORD: if (csts.done) state_in = ST_MULX;
         ST_MULX: state_in = ST_MULY;
         ST_MULY: state_in = ST_ADDY;
         ST_ADDY: state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cctl.start = (state_ff == ST_FOLD);
   end

   // wheel travel from the request
   always_comb begin
      l_w    = 33'(signed'(req_tdata[31:0])) - 33'(last_l_ff);
      r_w    = 33'(signed'(req_tdata[63:32])) - 33'(last_r_ff);
      diff_w = 34'(l_w) - 34'(r_w);
      mag_w  = diff_w[33] ? 34'(-diff_w) : 34'(diff_w);
      wd_eff = (wd_ff == 16'd0) ? 16'd1 : wd_ff;
      trial  = {rem_ff, dvd_ff[57]};
   end

   // midpoint angle, range reduction and fold
   always_comb begin
      half_w  = (dth_ff + $signed({31'd0, dth_ff[31]})) >>> 1;
      hsum_w  = 33'(h_ff) + 33'(half_w);
      mid_w   = {hsum_w, 6'd0};
      cmp_w   = TWO_PI_MAG << rk_ff;
      sred_w  = neg_ff ? -35'(signed'({1'b0, red_ff[33:0]}))
                       : 35'(signed'({1'b0, red_ff[33:0]}));
      if (sred_w > PI_Q30)       wrap_w = sred_w - TWO_PI_Q30;
      else if (sred_w < -PI_Q30) wrap_w = sred_w + TWO_PI_Q30;
      else                       wrap_w = sred_w;
      fneg_w = 1'b1;
      if (wrap_w > HALF_PI_Q30)       fold_w = PI_Q30 - wrap_w;
      else if (wrap_w < -HALF_PI_Q30) fold_w = -PI_Q30 - wrap_w;
      else begin
         fold_w = wrap_w;
         fneg_w = 1'b0;
      end
   end

   // shared multiplier
   always_comb begin
      cos_adj = negcos_ff ? -cos_w : cos_w;
      sn4     = 32'(sin_w >>> 2);
      cs4     = 32'(cos_adj >>> 2);
      mul_b   = (state_ff == ST_MULX) ? 66'(sn4) : 66'(cs4);
      mul_out = 66'(sum_ff) * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wd_ff     <= WD_RESET;
         last_l_ff <= '0;
         last_r_ff <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         h_ff      <= '0;
         rv_ff     <= 1'b0;
         dcnt_ff   <= '0;
         rk_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) wd_ff <= csr_wr_data;
         // response held until taken, loaded from the final state
         rv_ff <= (state_ff == ST_FIN && out_free) || (rv_ff && !rsp_tready);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_tuser)
                     MODE_SAMPLE: begin
                        last_l_ff <= signed'(req_tdata[31:0]);
                        last_r_ff <= signed'(req_tdata[63:32]);
                        sum_ff    <= 34'(l_w) + 34'(r_w);
                        neg_ff    <= diff_w[33];
                        dvd_ff    <= {mag_w, 24'd0};
                        rem_ff    <= '0;
                        q_ff      <= '0;
                        dcnt_ff   <= '0;
                     end
                     MODE_SET_X:   x_ff <= signed'(req_tdata[111:64]);
                     MODE_SET_Y:   y_ff <= signed'(req_tdata[159:112]);
                     MODE_SET_HDG: h_ff <= signed'(req_tdata[191:160]);
                     default: ;
                  endcase
               end
            end
            ST_DIV: begin
               dvd_ff  <= {dvd_ff[56:0], 1'b0};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (trial >= {1'b0, wd_eff}) begin
                  rem_ff <= 16'(trial - {1'b0, wd_eff});
                  q_ff   <= {q_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= trial[15:0];
                  q_ff   <= {q_ff[30:0], 1'b0};
               end
            end
            ST_MID: begin
               dth_ff <= neg_ff ? -signed'(q_ff) : signed'(q_ff);
               // after this the sign flag belongs to the angle
               rk_ff  <= RED_TOP;
            end
            ST_RED: begin
               if (rk_ff == RED_TOP) begin
                  neg_ff <= mid_w[38];
                  red_ff <= 39'(mid_w[38] ? -mid_w : mid_w);
               end else if (red_ff >= cmp_w) begin
                  red_ff <= red_ff - cmp_w;
               end
               rk_ff <= rk_ff - 3'd1;
            end
            ST_FOLD:  negcos_ff <= fneg_w;
            ST_CORD:  ;
            ST_MULX:  prod_ff <= mul_out;
            ST_MULY: begin
               x_ff    <= x_ff + 48'(prod_ff >>> 13);
               prod_ff <= mul_out;
            end
            ST_ADDY: begin
               y_ff <= y_ff + 48'(prod_ff >>> 13);
               h_ff <= h_ff + dth_ff;
            end
            ST_FIN: begin
               if (out_free) rd_ff <= {h_ff, y_ff, x_ff};
            end
            default: ;
         endcase
      end
   end

   ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cctl),
      .angle   (fold_w[33:0]),
      .sts     (csts),
      .sin_out (sin_w),
      .cos_out (cos_w)
   );

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   // assertions
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready) else $error("ready while busy");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FIN)) else $error("stray response");
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      csts.done |-> state_ff == ST_CORD) else $error("CORDIC done out of step");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dcnt_ff < 6'(DIV_STEPS)) else $error("divider overrun");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for differential drive odometry
// Drives encoder samples and set-x/y/heading requests through the request
// stream, predicts each position/heading response with a local fixed-point
// midpoint model (divider, angle reduction, CORDIC) and compares field by
// field. Runs several wheel_distance settings and back-pressure phases.
// ----------------------------------------------------------------------------
module tb;
   import ddo_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS      = 24;
   localparam int WDOG_LIMIT = 20000;
   localparam int SETTLE     = 120;

   localparam longint PI_V     = 64'sd3373259426;
   localparam longint TWO_PI_V = 64'sd6746518852;
   localparam longint HALF_PI  = 64'sd1686629713;
   localparam longint GAIN_V   = 64'sh26DD3B6A;

   // heading in the top bits, pos_x in the lowest, as on rsp_tdata
   typedef struct packed {
      logic signed [31:0] hdg;
      logic signed [47:0] py;
      logic signed [47:0] px;
   } odo_rsp_t;

   typedef struct {
      logic [1:0]         mode;
      logic signed [31:0] lc;
      logic signed [31:0] rc;
      logic signed [47:0] nx;
      logic signed [47:0] ny;
      logic signed [31:0] nh;
      logic               has_fixed;
      odo_rsp_t           fixed;
   } odo_req_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [1:0]    req_tuser = '0;   // mode
   // left_count, right_count, new_x, new_y, new_heading (low bits first)
   logic [191:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // pos_x, pos_y, heading (low bits first)
   logic [127:0]  rsp_tdata;

   differential_drive_odometry #(.CORDIC_STEPS(STEPS)) i_dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data, .req_tvalid, .req_tready,
      .req_tuser, .req_tdata, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   // odometry state held by the predictor
   logic [15:0]        wd_q;
   logic signed [31:0] prev_l, prev_r, hdg_q;
   logic signed [47:0] x_q, y_q;

   odo_rsp_t pose_queue[$];
   int   errors = 0;
   int   n_resp = 0;
   int   n_req  = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 1'b0;
   int   quiet = 0;

   initial forever #10 clock = ~clock;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   // midpoint dead-reckoning step, updates predictor state
   function automatic odo_rsp_t predict_pose(odo_req_t r);
      longint l, rr, wd, dth, mid, cx, cy, z, dx, dy, sn, cs, sum, a;
      bit neg_cos;
      odo_rsp_t o;
      case (r.mode)
         MODE_SAMPLE: begin
            l   = longint'(r.lc) - longint'(prev_l);
            rr  = longint'(r.rc) - longint'(prev_r);
            wd  = (wd_q == 0) ? 1 : longint'(wd_q);
            dth = longint'(signed'(32'((((l - rr) * (64'sd1 << 24)) / wd))));
            mid = (longint'(hdg_q) + dth / 2) * 64;
            mid = mid % TWO_PI_V;
            if (mid > PI_V) mid -= TWO_PI_V;
            else if (mid < -PI_V) mid += TWO_PI_V;
            a = mid;
            neg_cos = 1'b0;
            if (a > HALF_PI) begin
               a = PI_V - a;
               neg_cos = 1'b1;
            end else if (a < -HALF_PI) begin
               a = -PI_V - a;
               neg_cos = 1'b1;
            end
            cx = GAIN_V; cy = 0; z = a;
            for (int i = 0; i < STEPS; i++) begin
               dx = cy >>> i;
               dy = cx >>> i;
               if (z >= 0) begin
                  cx -= dx; cy += dy; z -= longint'(atan_q30(5'(i)));
               end else begin
                  cx += dx; cy -= dy; z += longint'(atan_q30(5'(i)));
               end
            end
            sn  = cy;
            cs  = neg_cos ? -cx : cx;
            sum = l + rr;
            x_q = 48'(longint'(x_q) + floor_shr(sum * (sn >>> 2), 13));
            y_q = 48'(longint'(y_q) + floor_shr(sum * (cs >>> 2), 13));
            hdg_q  = 32'(longint'(hdg_q) + dth);
            prev_l = r.lc;
            prev_r = r.rc;
         end
         MODE_SET_X: x_q = r.nx;
         MODE_SET_Y: y_q = r.ny;
         default:    hdg_q = r.nh;
      endcase
      o.px = x_q; o.py = y_q; o.hdg = hdg_q;
      return o;
   endfunction

   task automatic write_wheel_distance(logic [15:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wd_q = v;
   endtask

   task automatic send_request(odo_req_t r);
      odo_rsp_t p;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      p = predict_pose(r);
      if (r.has_fixed && p != r.fixed) begin
         $display("%t table row mismatch: expected %h actual %h", $time, r.fixed, p);
         errors++;
      end
      pose_queue.push_back(p);
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= {r.nh, r.ny, r.nx, r.rc, r.lc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_req++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic odo_req_t rand_request(bit sane);
      odo_req_t r;
      int k;
      r.has_fixed = 0; r.fixed = '0;
      k = $urandom_range(99);
      r.mode = (k < 80) ? MODE_SAMPLE : 2'($urandom_range(3));
      if (sane) begin
         r.lc = prev_l + 32'($signed($urandom_range(800)) - 400);
         r.rc = prev_r + 32'($signed($urandom_range(800)) - 400);
      end else begin
         r.lc = $urandom;
         r.rc = $urandom;
      end
      r.nx = 48'({$urandom, $urandom});
      r.ny = 48'({$urandom, $urandom});
      r.nh = $urandom;
      if (sane && $urandom_range(1)) begin
         r.nx = 48'($signed($urandom_range(2000000)) - 1000000);
         r.ny = 48'($signed($urandom_range(2000000)) - 1000000);
         r.nh = 32'($signed($urandom_range(200000000)) - 100000000);
      end
      return r;
   endfunction

   function automatic odo_req_t mk(logic [1:0] m, logic [31:0] lc, logic [31:0] rc,
                                   logic [47:0] nx, logic [47:0] ny, logic [31:0] nh);
      odo_req_t r;
      r.mode = m; r.lc = lc; r.rc = rc; r.nx = nx; r.ny = ny; r.nh = nh;
      r.has_fixed = 0; r.fixed = '0;
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      odo_rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pose_queue.size() == 0) begin
            $display("%t unexpected response: expected none actual %h", $time, got);
            errors++;
         end else begin
            want = pose_queue.pop_front();
            n_resp++;
            if (got.px !== want.px) begin
               $display("%t pos_x: expected %h actual %h", $time, want.px, got.px);
               errors++;
            end
            if (got.py !== want.py) begin
               $display("%t pos_y: expected %h actual %h", $time, want.py, got.py);
               errors++;
            end
            if (got.hdg !== want.hdg) begin
               $display("%t heading: expected %h actual %h", $time, want.hdg, got.hdg);
               errors++;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on accepted handshakes
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || hold_off)
         quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", quiet);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      odo_req_t tbl[$];
      odo_req_t r;
      logic [15:0] wd_set[5];
      wd_set = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd57};
      wd_q = WD_RESET; prev_l = 0; prev_r = 0; hdg_q = 0; x_q = 0; y_q = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: zero sample after reset, extremes of every field
      r = mk(MODE_SAMPLE, 0, 0, 0, 0, 0);
      r.has_fixed = 1; r.fixed = '0;
      tbl.push_back(r);
      r = mk(MODE_SET_X, 0, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
      r.has_fixed = 1;
      r.fixed = '{px: 48'h7FFF_FFFF_FFFF, py: 48'h0, hdg: 32'h0};
      tbl.push_back(r);
      r = mk(MODE_SET_Y, 0, 0, 0, 48'h8000_0000_0000, 0);
      r.has_fixed = 1;
      r.fixed = '{px: 48'h7FFF_FFFF_FFFF, py: 48'h8000_0000_0000, hdg: 32'h0};
      tbl.push_back(r);
      r = mk(MODE_SET_HDG, 0, 0, 0, 0, 32'h8000_0000);
      r.has_fixed = 1;
      r.fixed = '{px: 48'h7FFF_FFFF_FFFF, py: 48'h8000_0000_0000, hdg: 32'h8000_0000};
      tbl.push_back(r);
      tbl.push_back(mk(MODE_SET_HDG, 0, 0, 0, 0, 32'h7FFF_FFFF));
      tbl.push_back(mk(MODE_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
      tbl.push_back(mk(MODE_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
      tbl.push_back(mk(MODE_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
      tbl.push_back(mk(MODE_SAMPLE, 32'd1000, 32'd1000, 0, 0, 0));  // straight line
      tbl.push_back(mk(MODE_SET_X, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 0));
      tbl.push_back(mk(MODE_SET_Y, 0, 0, 0, 48'h0000_0001_0000, 0));
      tbl.push_back(mk(MODE_SET_HDG, 0, 0, 0, 0, 32'h3243F6A8));  // heading about 16*pi, reduces to near zero
      tbl.push_back(mk(MODE_SAMPLE, 32'd1400, 32'd1000, 0, 0, 0));
      tbl.push_back(mk(MODE_SAMPLE, 32'd1400, 32'd1900, 0, 0, 0));
      tbl.push_back(mk(MODE_SET_HDG, 0, 0, 0, 0, 32'hCDBC0958));  // heading about -16*pi, reduces to near zero
      tbl.push_back(mk(MODE_SAMPLE, 32'd1500, 32'd2000, 0, 0, 0));
      tbl.push_back(mk(MODE_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0));
      foreach (tbl[i]) send_request(tbl[i]);
      drain();

      // random phases, one wheel_distance setting each
      for (int ph = 0; ph < 5; ph++) begin
         write_wheel_distance(wd_set[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         if (ph == 4) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (600) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 300; n++)
            send_request(rand_request($urandom_range(99) < 85));
         drain();
      end

      $display("covered %0d requests, %0d responses checked over 5 wheel distances",
               n_req, n_resp);
      $display("idle and stall phases included a long receiver hold-off");
      if (errors == 0 && pose_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
